@@ hdl/bdh_pkg.sv @@
`timescale 1ns / 1ps

package bdh_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int DEF_PIXEL_BITS = 16;
   localparam int CFG_BITS       = 13;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic emit;
      logic from_line;
      logic frame_end;
   } pair_ctl_type;

endpackage

@@ hdl/bdh_line_mem.sv @@
`timescale 1ns / 1ps

module bdh_line_mem #(
   parameter int DEPTH     = 2048,
   parameter int ADDR_BITS = 11,
   parameter int DATA_BITS = 17
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data_ff
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/bdh_ctrl.sv @@
`timescale 1ns / 1ps

module bdh_ctrl #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int PIXEL_BITS = 16,
   parameter int WIDTH_BITS = 13,
   parameter int HEIGHT_BITS = 13,
   parameter int ADDR_BITS  = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   clear,
   input  logic [PIXEL_BITS-1:0]  pixel,
   input  logic                   frame_start,
   input  logic [WIDTH_BITS-1:0]  width,
   input  logic [HEIGHT_BITS-1:0] height,
   output bdh_pkg::pair_ctl_type  ctl,
   output logic [PIXEL_BITS:0]    pair,
   output logic                   line_we,
   output logic                   line_re,
   output logic [ADDR_BITS-1:0]   line_addr
);

   import bdh_pkg::*;

   localparam int COL_BITS = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_BITS = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

   logic [PIXEL_BITS-1:0] held_ff, held_in;
   logic [COL_BITS-1:0]   col_ff, col_in, x;
   logic [ROW_BITS-1:0]   row_ff, row_in, y;
   logic                  last_col, last_row, pair_done;

   always_comb begin
      x = frame_start ? '0 : col_ff;
      y = frame_start ? '0 : row_ff;
      if (WIDTH_BITS'(x) >= width) begin
         x = '0;
      end
      if (HEIGHT_BITS'(y) >= height) begin
         y = '0;
      end
      last_col  = (WIDTH_BITS'(x) + WIDTH_BITS'(1)) == width;
      last_row  = (HEIGHT_BITS'(y) + HEIGHT_BITS'(1)) == height;
      pair_done = x[0] | last_col;
      pair      = x[0] ? ({1'b0, held_ff} + {1'b0, pixel}) : ({1'b0, pixel} + {1'b0, pixel});
      line_addr = ADDR_BITS'(x >> 1);
      line_we   = take & pair_done & ~y[0];
      line_re   = take & pair_done & y[0];

      ctl.emit      = pair_done & (y[0] | last_row);
      ctl.from_line = y[0];
      ctl.frame_end = last_col & last_row;

      held_in = x[0] ? held_ff : pixel;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : y + ROW_BITS'(1);
      end else begin
         col_in = x + COL_BITS'(1);
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else if (clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         held_ff <= held_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

@@ hdl/box_downscale_half.sv @@
`timescale 1ns / 1ps

// Half-size 2x2 box downscaler for one pixel plane.
// Pixels enter in raster order on the req_ stream, one word per clock at most;
// req_tuser marks the first pixel of a plane and restarts the position counters.
// Each result word on rsp_ is the 2x2 average rounded half up; rsp_tlast marks the
// last output pixel of the plane. An odd last column or row is paired with itself.
// The csr_ port writes image_width (index 0) and image_height (index 1); a value of
// zero counts as one and a value above the maximum counts as the maximum. A write
// also restarts the counters. Write these only while no pixel is in flight.
// Throughput is one pixel per clock when not stalled. The last pixel of a block is
// registered in the middle stage as the line store is read; its result then goes to
// the output register. Even rows leave their horizontal pair sums in the line store;
// odd rows read them back, so the store is never read and written at the same entry
// at once. When rsp_tready is low the output register holds, the middle stage fills,
// and then req_tready drops until the output moves. Reset sets both sizes to one and
// clears the counters and the held pixel; the line store is not cleared.
module box_downscale_half #(
   parameter int MAX_WIDTH  = bdh_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bdh_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = bdh_pkg::DEF_PIXEL_BITS,
   parameter int DATA_BITS  = ((PIXEL_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [DATA_BITS-1:0]         req_tdata,   // pixel_value
   input  logic                         req_tuser,   // frame_start
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [DATA_BITS-1:0]         rsp_tdata,   // out_value
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  bdh_pkg::csr_index_type       csr_index,
   input  logic [bdh_pkg::CFG_BITS-1:0] csr_data
);

   import bdh_pkg::*;

   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int LINE_DEPTH  = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_BITS   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [31:0]            cfg_wide;
   logic                   cfg_write, take, s1_move;
   pair_ctl_type           ctl, s1_ctl_ff;
   logic [PIXEL_BITS:0]    pair, s1_pair_ff, line_rd;
   logic                   line_we, line_re;
   logic [ADDR_BITS-1:0]   line_addr;
   logic                   s1_valid_ff, out_valid_ff, out_last_ff;
   logic [PIXEL_BITS+1:0]  sum, rounded;
   logic [PIXEL_BITS-1:0]  out_value_ff;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid & csr_ready;
   assign cfg_wide  = 32'(csr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1);
         height_ff <= HEIGHT_BITS'(1);
      end else if (cfg_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (cfg_wide == 32'd0) begin
                  width_ff <= WIDTH_BITS'(1);
               end else if (cfg_wide > 32'(MAX_WIDTH)) begin
                  width_ff <= WIDTH_BITS'(MAX_WIDTH);
               end else begin
                  width_ff <= WIDTH_BITS'(cfg_wide);
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (cfg_wide == 32'd0) begin
                  height_ff <= HEIGHT_BITS'(1);
               end else if (cfg_wide > 32'(MAX_HEIGHT)) begin
                  height_ff <= HEIGHT_BITS'(MAX_HEIGHT);
               end else begin
                  height_ff <= HEIGHT_BITS'(cfg_wide);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_move    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | s1_move;
   assign take       = req_tvalid & req_tready;

   bdh_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS),
      .WIDTH_BITS (WIDTH_BITS),
      .HEIGHT_BITS(HEIGHT_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .clear      (cfg_write),
      .pixel      (req_tdata[PIXEL_BITS-1:0]),
      .frame_start(req_tuser),
      .width      (width_ff),
      .height     (height_ff),
      .ctl        (ctl),
      .pair       (pair),
      .line_we    (line_we),
      .line_re    (line_re),
      .line_addr  (line_addr)
   );

   bdh_line_mem #(
      .DEPTH    (LINE_DEPTH),
      .ADDR_BITS(ADDR_BITS),
      .DATA_BITS(PIXEL_BITS + 1)
   ) u_line (
      .clock     (clock),
      .wr_en     (line_we),
      .wr_addr   (line_addr),
      .wr_data   (pair),
      .rd_en     (line_re),
      .rd_addr   (line_addr),
      .rd_data_ff(line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= take & ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ctl_ff  <= ctl;
         s1_pair_ff <= pair;
      end
   end

   always_comb begin
      sum     = (s1_ctl_ff.from_line ? {1'b0, line_rd} : {1'b0, s1_pair_ff})
                + {1'b0, s1_pair_ff};
      rounded = sum + (PIXEL_BITS + 2)'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_value_ff <= rounded[PIXEL_BITS+1:2];
         out_last_ff  <= s1_ctl_ff.frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_BITS'(out_value_ff);
   assign rsp_tlast  = out_last_ff;

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && out_valid_ff)
      else $error("input stalled with a free stage");

   a_line_port: assert property (@(posedge clock) disable iff (reset)
      !(line_we && line_re))
      else $error("line store read and written by one pixel");

   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_move |=> out_valid_ff)
      else $error("middle stage result lost");

endmodule
